### rtl/rqoa_pkg.sv
// ---------------------------------------------------------------------------
// rqoa_pkg
// Shared widths, codes and payload types of the ring queue with running
// average.
// ---------------------------------------------------------------------------
`default_nettype none

package rqoa_pkg;

	localparam int YEAR_W    = 16;
	localparam int TAG_W     = 9;
	localparam int COUNT_W   = 6;
	localparam int SUM_W     = 22;
	localparam int ENTRY_W   = YEAR_W + TAG_W;
	localparam int SLOTS_DEF = 5;

	localparam int DIV_W     = 24;
	localparam int DIV_STEP  = 8;
	localparam int DIV_ITER  = DIV_W / DIV_STEP;
	localparam int DIV_CNT_W = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [YEAR_W-1:0] average_year;
		logic signed [YEAR_W-1:0] removed_year;
		logic [TAG_W-1:0]         removed_tag;
		logic                     empty_error;
		logic [COUNT_W-1:0]       held_count;
	} result_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

`default_nettype wire

### rtl/rqoa_in_if.sv
// ---------------------------------------------------------------------------
// rqoa_in_if
// Command channel: one beat carries an operation and an entry to insert.
// ---------------------------------------------------------------------------
`default_nettype none

interface rqoa_in_if;

	logic                               valid;
	logic                               ready;
	rqoa_pkg::op_t                      operation;
	logic signed [rqoa_pkg::YEAR_W-1:0] year_value;
	logic [rqoa_pkg::TAG_W-1:0]         record_tag;

	modport source (output valid, operation, year_value, record_tag, input ready);
	modport sink   (input valid, operation, year_value, record_tag, output ready);

endinterface

`default_nettype wire

### rtl/rqoa_out_if.sv
// ---------------------------------------------------------------------------
// rqoa_out_if
// Result channel: one beat per command with the average or the removed entry.
// ---------------------------------------------------------------------------
`default_nettype none

interface rqoa_out_if;

	logic                               valid;
	logic                               ready;
	logic signed [rqoa_pkg::YEAR_W-1:0] average_year;
	logic signed [rqoa_pkg::YEAR_W-1:0] removed_year;
	logic [rqoa_pkg::TAG_W-1:0]         removed_tag;
	logic                               empty_error;
	logic [rqoa_pkg::COUNT_W-1:0]       held_count;

	modport source (output valid, average_year, removed_year, removed_tag, empty_error,
		held_count, input ready);
	modport sink   (input valid, average_year, removed_year, removed_tag, empty_error,
		held_count, output ready);

endinterface

`default_nettype wire

### rtl/rqoa_ram.sv
// ---------------------------------------------------------------------------
// rqoa_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module rqoa_ram #(
	parameter int WIDTH = rqoa_pkg::ENTRY_W,
	parameter int DEPTH = rqoa_pkg::SLOTS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/rqoa_div.sv
// ---------------------------------------------------------------------------
// rqoa_div
// Signed by unsigned divider, truncating toward zero, eight quotient bits
// per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rqoa_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [rqoa_pkg::SUM_W-1:0]   dividend,
	input  wire logic [rqoa_pkg::COUNT_W-1:0]        divisor,
	output logic                                     done,
	output logic signed [rqoa_pkg::YEAR_W-1:0]       quotient
);

	localparam int DW = rqoa_pkg::DIV_W;
	localparam int CW = rqoa_pkg::COUNT_W;

	logic                          busy_q;
	logic                          done_q;
	logic [rqoa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          neg_q;
	logic [DW-1:0]                 dvd_q;
	logic [CW:0]                   rem_q;
	logic [CW-1:0]                 dsr_q;
	logic signed [rqoa_pkg::YEAR_W-1:0] quot_q;

	logic [rqoa_pkg::SUM_W-1:0] mag;
	logic [DW-1:0]              dvd_nxt;
	logic [CW:0]                rem_nxt;

	assign mag = dividend[rqoa_pkg::SUM_W-1] ? rqoa_pkg::SUM_W'(-dividend)
		: rqoa_pkg::SUM_W'(dividend);

	always_comb begin
		logic [DW-1:0] d;
		logic [CW:0]   r;
		d = dvd_q;
		r = rem_q;
		for (int k = 0; k < rqoa_pkg::DIV_STEP; k++) begin
			r = {r[CW-1:0], d[DW-1]};
			d = {d[DW-2:0], 1'b0};
			if (r >= {1'b0, dsr_q}) begin
				r = r - {1'b0, dsr_q};
				d[0] = 1'b1;
			end
		end
		dvd_nxt = d;
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rqoa_pkg::DIV_CNT_W'(rqoa_pkg::DIV_ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {{(DW - rqoa_pkg::SUM_W){1'b0}}, mag};
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[rqoa_pkg::SUM_W-1];
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
			if (cnt_q == rqoa_pkg::DIV_CNT_W'(rqoa_pkg::DIV_ITER - 1)) begin
				quot_q <= neg_q ? -dvd_nxt[rqoa_pkg::YEAR_W-1:0]
					: dvd_nxt[rqoa_pkg::YEAR_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

### rtl/ring_queue_overwrite_average.sv
// ---------------------------------------------------------------------------
// ring_queue_overwrite_average
// Circular queue of year and tag entries with overwrite and running average.
// ---------------------------------------------------------------------------
// Commands arrive on req as beats of operation, year_value and record_tag;
// each command gives exactly one beat on rsp. An insert drops the oldest
// entry when SLOTS-1 entries are held, appends the new one and reports the
// average of all held years, truncated toward zero. A remove reports the
// oldest entry, or raises empty_error when nothing is held.
// The entries live in one RAM with a registered read; the head slot is read
// at the edge that accepts a command, and an insert writes the tail slot in
// the cycle after that edge.
// An insert updates the queue in S_MOD, starts the divider there and loads
// the average into its result register once the divider is done; the
// divider produces eight quotient bits per cycle. A remove loads its result
// register in S_MOD. One command is in flight at a time; req.ready is high
// while the block waits for a command, even when a result is still held on
// rsp. If rsp stalls, the next result waits until the register is free.
// Reset empties the queue and clears the running sum; the RAM is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module ring_queue_overwrite_average #(
	parameter int SLOTS = rqoa_pkg::SLOTS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rqoa_in_if.sink    req,
	rqoa_out_if.source rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int YW    = rqoa_pkg::YEAR_W;
	localparam int TW    = rqoa_pkg::TAG_W;
	localparam int SW    = rqoa_pkg::SUM_W;
	localparam int CW    = rqoa_pkg::COUNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_DIV,
		S_OUT
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       head_q;
	logic [IDX_W-1:0]       tail_q;
	logic [CW-1:0]          count_q;
	logic signed [SW-1:0]   sum_q;
	rqoa_pkg::op_t          op_q;
	logic signed [YW-1:0]   year_q;
	logic [TW-1:0]          tag_q;
	logic                   full_q;
	logic                   empty_q;
	rqoa_pkg::result_t      res_q;
	rqoa_pkg::result_t      out_q;
	logic                   out_valid_q;

	logic [rqoa_pkg::ENTRY_W-1:0] rdata;
	logic signed [YW-1:0]   rd_year;
	logic [TW-1:0]          rd_tag;
	logic [IDX_W-1:0]       head_nxt;
	logic [IDX_W-1:0]       tail_nxt;
	logic signed [SW-1:0]   drop_ext;
	logic signed [SW-1:0]   year_ext;
	logic signed [SW-1:0]   sum_ins;
	logic [CW-1:0]          count_ins;
	rqoa_pkg::div_ctl_t     div_ctl;
	logic signed [YW-1:0]   quotient;
	logic                   accept;
	logic                   out_free;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign rd_year  = rdata[rqoa_pkg::ENTRY_W-1:TW];
	assign rd_tag   = rdata[TW-1:0];
	assign head_nxt = (head_q == IDX_W'(SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == IDX_W'(SLOTS - 1)) ? '0 : tail_q + 1'b1;

	assign drop_ext  = {{(SW - YW){rd_year[YW-1]}}, rd_year};
	assign year_ext  = {{(SW - YW){year_q[YW-1]}}, year_q};
	assign sum_ins   = full_q ? sum_q - drop_ext + year_ext : sum_q + year_ext;
	assign count_ins = full_q ? count_q : count_q + 1'b1;

	assign div_ctl.start = (state_q == S_MOD) && (op_q == rqoa_pkg::OP_INSERT);

	rqoa_ram #(
		.WIDTH (rqoa_pkg::ENTRY_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (div_ctl.start),
		.waddr (tail_q),
		.wdata ({year_q, tag_q}),
		.raddr (head_q),
		.rdata (rdata)
	);

	rqoa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_ctl.start),
		.dividend (sum_ins),
		.divisor  (count_ins),
		.done     (div_ctl.done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (op_q == rqoa_pkg::OP_INSERT) begin
						sum_q   <= sum_ins;
						count_q <= count_ins;
						tail_q  <= tail_nxt;
						if (full_q) begin
							head_q <= head_nxt;
						end
						res_q.average_year <= '0;
						res_q.removed_year <= '0;
						res_q.removed_tag  <= '0;
						res_q.empty_error  <= 1'b0;
						res_q.held_count   <= count_ins;
						state_q <= S_DIV;
					end else if (empty_q) begin
						res_q.average_year <= '0;
						res_q.removed_year <= '0;
						res_q.removed_tag  <= '0;
						res_q.empty_error  <= 1'b1;
						res_q.held_count   <= '0;
						state_q <= S_OUT;
					end else begin
						sum_q   <= sum_q - drop_ext;
						count_q <= count_q - 1'b1;
						head_q  <= head_nxt;
						res_q.average_year <= '0;
						res_q.removed_year <= rd_year;
						res_q.removed_tag  <= rd_tag;
						res_q.empty_error  <= 1'b0;
						res_q.held_count   <= count_q - 1'b1;
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_ctl.done) begin
						res_q.average_year <= quotient;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			year_q  <= req.year_value;
			tag_q   <= req.record_tag;
			full_q  <= (count_q == CW'(SLOTS - 1));
			empty_q <= (count_q == '0);
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.average_year = out_q.average_year;
	assign rsp.removed_year = out_q.removed_year;
	assign rsp.removed_tag  = out_q.removed_tag;
	assign rsp.empty_error  = out_q.empty_error;
	assign rsp.held_count   = out_q.held_count;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS - 1))
		else $error("held count exceeds capacity");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (head_q == tail_q))
		else $error("count and pointers disagree");

	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.empty_error |-> rsp.held_count == '0)
		else $error("empty error with entries held");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("second command taken while one is in flight");

endmodule

`default_nettype wire
